// ===== hw/rtl/oaht_pkg.sv =====
// Package of shared constants, codes and the hash mixing step for the hash table.
package oaht_pkg;

   localparam int SLOT_COUNT_LOG2_DEF = 10;
   localparam int SHIFT_MIN           = 3;
   localparam logic [3:0] SHIFT_RESET = 4'd10;
   localparam int SLOT_W              = 10;

   localparam logic [1:0] ST_EMPTY = 2'd0;
   localparam logic [1:0] ST_VALID = 2'd1;
   localparam logic [1:0] ST_TOMB  = 2'd2;

   localparam logic [1:0] MODE_LOOKUP = 2'd0;
   localparam logic [1:0] MODE_INSERT = 2'd1;
   localparam logic [1:0] MODE_REMOVE = 2'd2;
   localparam logic [1:0] MODE_NOP    = 2'd3;

   localparam logic [1:0] MIX_A = 2'd0;
   localparam logic [1:0] MIX_B = 2'd1;
   localparam logic [1:0] MIX_C = 2'd2;

   // One round of the key mix: an add of shifted copies followed by a shifted xor.
   function automatic logic [63:0] mix_stage(input logic [63:0] k, input logic [1:0] step);
      logic [63:0] t;
      case (step)
         MIX_A: begin
            t = (~k) + (k << 18);
            return t ^ (t >> 31);
         end
         MIX_B: begin
            t = (k << 4) + (k << 2) + k;
            return t ^ (t >> 11);
         end
         default: begin
            t = k + (k << 6);
            return t ^ (t >> 22);
         end
      endcase
   endfunction

endpackage

// ===== hw/rtl/open_addressing_hash_table.sv =====
// Top level of the open-addressed hash table with triangular probing.
//
// A request transaction is accepted at a rising edge where start is high and busy
// is low; it carries a mode (lookup, insert, remove or no-op), a key, a value and a
// range length. Each request produces exactly one response transaction, shown on
// the rsp_ ports for one cycle while rsp_valid is high. The receiver cannot stall
// the response, so it must take it in that cycle.
// A no-op request goes straight to the finish state. Other modes first hash the key
// (load the key mixer, three mixer rounds and form the home slot), then take a slot
// memory read and its evaluation for each probe, then write and respond in the
// finish state; the response is registered. The probe chain length sets the rate;
// at moderate load a request needs one or two probes, and a full table needs
// 2^table_shift probes.
// Only one request is in flight; busy stays high until its response is shown.
// After reset the slot status memory is cleared one slot per cycle, and busy stays
// high until every slot is cleared. The table_shift register is written via
// csr_we/csr_wdata; the active shift follows it at once, also for a request in
// flight. It resets to 10 and is clamped to 3 .. SLOT_COUNT_LOG2.
module open_addressing_hash_table
   import oaht_pkg::*;
#(
   parameter int SLOT_COUNT_LOG2 = SLOT_COUNT_LOG2_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_mode,
   input  logic [63:0] req_key,
   input  logic [63:0] req_value,
   input  logic [31:0] req_range_len,
   output logic        rsp_valid,
   output logic        rsp_success,
   output logic        rsp_table_full,
   output logic [63:0] rsp_value_out,
   output logic [31:0] rsp_size_out,
   output logic [SLOT_W-1:0] rsp_slot,
   input  logic        csr_we,
   input  logic [3:0]  csr_wdata
);

   localparam int N = SLOT_COUNT_LOG2;
   localparam int DEPTH = 1 << N;

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_CLEAR  = 3'd1;
   localparam logic [2:0] S_HASH   = 3'd2;
   localparam logic [2:0] S_PROBE  = 3'd3;
   localparam logic [2:0] S_EVAL   = 3'd4;
   localparam logic [2:0] S_FINISH = 3'd5;

   logic [2:0]  state_ff, state_in;
   logic [3:0]  shift_ff;
   logic [N-1:0] clr_ff, clr_in;

   logic [1:0]  mode_ff;
   logic [63:0] key_ff, value_ff;
   logic [31:0] len_ff;

   logic [N-1:0] idx_ff, idx_in;
   logic [N:0]   cnt_ff, cnt_in;
   logic         found_ff, found_in;
   logic         empty_ff, empty_in;
   logic         tomb_ff, tomb_in;
   logic         full_ff, full_in;
   logic [N-1:0] tomb_idx_ff, tomb_idx_in;
   logic [63:0]  hit_value_ff, hit_value_in;
   logic [31:0]  hit_len_ff, hit_len_in;

   logic         rsp_valid_ff, rsp_valid_in;
   logic         rsp_success_ff, rsp_success_in;
   logic         rsp_full_ff, rsp_full_in;
   logic [63:0]  rsp_value_ff, rsp_value_in;
   logic [31:0]  rsp_size_ff, rsp_size_in;
   logic [SLOT_W-1:0] rsp_slot_ff, rsp_slot_in;

   // The slot store: status, key, value and range length memories.
   logic [1:0]  status_mem [DEPTH];
   logic [63:0] key_mem    [DEPTH];
   logic [63:0] value_mem  [DEPTH];
   logic [31:0] len_mem    [DEPTH];
   logic [1:0]  st_rd;
   logic [63:0] key_rd, value_rd;
   logic [31:0] len_rd;

   logic         st_we, data_we;
   logic [N-1:0] st_waddr, data_waddr;
   logic [1:0]   st_wdata;
   logic [31:0]  len_wdata;

   logic        mix_load, mix_done;
   logic [31:0] mix_hash;
   logic        kick_ff;

   logic [5:0]   act_shift;
   logic [N:0]   size;
   logic [N-1:0] mask;
   logic [31:0]  hash_fix;
   logic [N:0]   cnt_next;
   logic         accept;

   oaht_mix u_mix (
      .clock (clock),
      .reset (reset),
      .load  (mix_load),
      .key   (key_ff),
      .done  (mix_done),
      .hash  (mix_hash)
   );

   // The active shift is clamped to the range the table supports.
   always_comb begin
      if (shift_ff < 4'(SHIFT_MIN)) begin
         act_shift = 6'(SHIFT_MIN);
      end else if (32'(shift_ff) > N) begin
         act_shift = 6'(N);
      end else begin
         act_shift = 6'(shift_ff);
      end
      size = (N + 1)'(1) << act_shift;
      mask = N'(size - (N + 1)'(1));
   end

   assign hash_fix = (mix_hash < 32'd2) ? 32'd2 : mix_hash;
   assign cnt_next = cnt_ff + (N + 1)'(1);
   assign accept   = start && !busy;
   assign busy     = (state_ff != S_IDLE);

   always_comb begin
      state_in       = state_ff;
      clr_in         = clr_ff;
      idx_in         = idx_ff;
      cnt_in         = cnt_ff;
      found_in       = found_ff;
      empty_in       = empty_ff;
      tomb_in        = tomb_ff;
      full_in        = full_ff;
      tomb_idx_in    = tomb_idx_ff;
      hit_value_in   = hit_value_ff;
      hit_len_in     = hit_len_ff;
      rsp_valid_in   = 1'b0;
      rsp_success_in = 1'b0;
      rsp_full_in    = 1'b0;
      rsp_value_in   = 64'd0;
      rsp_size_in    = 32'd0;
      rsp_slot_in    = '0;
      mix_load       = kick_ff;
      st_we          = 1'b0;
      st_waddr       = idx_ff;
      st_wdata       = ST_EMPTY;
      data_we        = 1'b0;
      data_waddr     = idx_ff;
      len_wdata      = len_ff;

      case (state_ff)
         S_CLEAR: begin
            st_we    = 1'b1;
            st_waddr = clr_ff;
            st_wdata = ST_EMPTY;
            clr_in   = clr_ff + N'(1);
            if (clr_ff == N'(DEPTH - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (accept) begin
               found_in = 1'b0;
               empty_in = 1'b0;
               tomb_in  = 1'b0;
               full_in  = 1'b0;
               cnt_in   = '0;
               state_in = (req_mode == MODE_NOP) ? S_FINISH : S_HASH;
            end
         end
         S_HASH: begin
            if (mix_done) begin
               idx_in   = hash_fix[N-1:0] & mask;
               state_in = S_PROBE;
            end
         end
         S_PROBE: begin
            state_in = S_EVAL;
         end
         S_EVAL: begin
            if (st_rd == ST_EMPTY) begin
               empty_in = 1'b1;
               state_in = S_FINISH;
            end else if (st_rd == ST_VALID && key_rd == key_ff) begin
               found_in     = 1'b1;
               hit_value_in = value_rd;
               hit_len_in   = len_rd;
               state_in     = S_FINISH;
            end else begin
               if (st_rd == ST_TOMB && !tomb_ff) begin
                  tomb_in     = 1'b1;
                  tomb_idx_in = idx_ff;
               end
               cnt_in = cnt_next;
               if (cnt_next == size) begin
                  full_in  = 1'b1;
                  state_in = S_FINISH;
               end else begin
                  idx_in   = (idx_ff + cnt_ff[N-1:0] + N'(1)) & mask;
                  state_in = S_PROBE;
               end
            end
         end
         S_FINISH: begin
            state_in     = S_IDLE;
            rsp_valid_in = 1'b1;
            rsp_full_in  = full_ff;
            case (mode_ff)
               MODE_LOOKUP: begin
                  if (found_ff) begin
                     rsp_success_in = 1'b1;
                     rsp_value_in   = hit_value_ff;
                     rsp_size_in    = hit_len_ff;
                     rsp_slot_in    = SLOT_W'(32'(idx_ff));
                  end
               end
               MODE_INSERT: begin
                  if (found_ff) begin
                     rsp_slot_in = SLOT_W'(32'(idx_ff));
                  end else if (tomb_ff || empty_ff) begin
                     st_we          = 1'b1;
                     data_we        = 1'b1;
                     st_waddr       = tomb_ff ? tomb_idx_ff : idx_ff;
                     data_waddr     = st_waddr;
                     st_wdata       = ST_VALID;
                     rsp_success_in = 1'b1;
                     rsp_slot_in    = SLOT_W'(32'(st_waddr));
                  end
               end
               MODE_REMOVE: begin
                  if (found_ff) begin
                     st_we          = 1'b1;
                     st_wdata       = ST_TOMB;
                     rsp_success_in = 1'b1;
                     rsp_slot_in    = SLOT_W'(32'(idx_ff));
                  end
               end
               default: begin
               end
            endcase
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // The mixer is started in the cycle after acceptance, once the key is registered.
   always_ff @(posedge clock) begin
      if (reset) begin
         kick_ff <= 1'b0;
      end else begin
         kick_ff <= accept && (req_mode != MODE_NOP);
      end
   end

   // Memories: one write and one registered read per cycle each.
   always_ff @(posedge clock) begin
      if (st_we) begin
         status_mem[st_waddr] <= st_wdata;
      end
      st_rd <= status_mem[idx_ff];
   end

   always_ff @(posedge clock) begin
      if (data_we) begin
         key_mem[data_waddr]   <= key_ff;
         value_mem[data_waddr] <= value_ff;
      end
      key_rd   <= key_mem[idx_ff];
      value_rd <= value_mem[idx_ff];
   end

   // A remove clears the range length together with the tombstone write.
   always_ff @(posedge clock) begin
      if (data_we || (st_we && st_wdata == ST_TOMB)) begin
         len_mem[st_waddr] <= (st_wdata == ST_TOMB) ? 32'd0 : len_wdata;
      end
      len_rd <= len_mem[idx_ff];
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         mode_ff  <= req_mode;
         key_ff   <= req_key;
         value_ff <= req_value;
         len_ff   <= req_range_len;
      end
      idx_ff       <= idx_in;
      tomb_idx_ff  <= tomb_idx_in;
      hit_value_ff <= hit_value_in;
      hit_len_ff   <= hit_len_in;
      rsp_success_ff <= rsp_success_in;
      rsp_full_ff    <= rsp_full_in;
      rsp_value_ff   <= rsp_value_in;
      rsp_size_ff    <= rsp_size_in;
      rsp_slot_ff    <= rsp_slot_in;
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         cnt_ff       <= '0;
         found_ff     <= 1'b0;
         empty_ff     <= 1'b0;
         tomb_ff      <= 1'b0;
         full_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         cnt_ff       <= cnt_in;
         found_ff     <= found_in;
         empty_ff     <= empty_in;
         tomb_ff      <= tomb_in;
         full_ff      <= full_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         shift_ff <= SHIFT_RESET;
      end else if (csr_we) begin
         shift_ff <= csr_wdata;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_success    = rsp_success_ff;
   assign rsp_table_full = rsp_full_ff;
   assign rsp_value_out  = rsp_value_ff;
   assign rsp_size_out   = rsp_size_ff;
   assign rsp_slot       = rsp_slot_ff;

endmodule

// ===== hw/rtl/oaht_mix.sv =====
// Iterative key mixer that turns a 64-bit key into a 32-bit hash through the mix rounds A, B and C in turn.
module oaht_mix
   import oaht_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        load,
   input  logic [63:0] key,
   output logic        done,
   output logic [31:0] hash
);

   logic [63:0] k_ff, k_in;
   logic [1:0]  step_ff, step_in;
   logic        run_ff, run_in;
   logic        done_ff, done_in;

   always_comb begin
      k_in    = k_ff;
      step_in = step_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      if (load) begin
         k_in    = key;
         step_in = MIX_A;
         run_in  = 1'b1;
      end else if (run_ff) begin
         k_in = mix_stage(k_ff, step_ff);
         if (step_ff == MIX_C) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end else begin
            step_in = step_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      k_ff    <= k_in;
      step_ff <= step_in;
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
   end

   assign done = done_ff;
   assign hash = k_ff[31:0];

endmodule

// ===== hw/rtl/oaht_checker.sv =====
// Port-level checker for the hash table and the bind that attaches it.
module oaht_checker
   import oaht_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        start,
   input logic        busy,
   input logic        rsp_valid,
   input logic        rsp_success,
   input logic [63:0] rsp_value_out,
   input logic [31:0] rsp_size_out
);

   a_rsp_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("response strobe lasted more than one cycle");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("busy did not rise after a request transaction");

   a_rsp_from_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy))
      else $error("response without a request in flight");

   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_success) |-> (rsp_value_out == 64'd0 && rsp_size_out == 32'd0))
      else $error("failed response carries data");

   a_reset_clear: assert property (@(posedge clock)
      reset |=> busy)
      else $error("table not busy clearing after reset");

endmodule

bind open_addressing_hash_table oaht_checker u_oaht_checker (
   .clock         (clock),
   .reset         (reset),
   .start         (start),
   .busy          (busy),
   .rsp_valid     (rsp_valid),
   .rsp_success   (rsp_success),
   .rsp_value_out (rsp_value_out),
   .rsp_size_out  (rsp_size_out)
);

// ===== test/open_addressing_hash_table_test.sv =====
// Self-checking testbench for the open-addressed hash table with triangular probing.
`timescale 1ns / 100ps

class hash_table_scoreboard;
   logic [1:0]  status_mem [1024];
   logic [63:0] key_mem    [1024];
   logic [63:0] value_mem  [1024];
   logic [31:0] length_mem [1024];
   logic [3:0]  shift_reg;
   logic [1:0]  pending_success_full [$];
   logic [63:0] pending_value [$];
   logic [31:0] pending_size [$];
   logic [9:0]  pending_slot [$];
   int          error_count;

   function new();
      for (int i = 0; i < 1024; i++) begin
         status_mem[i] = oaht_pkg::ST_EMPTY;
         key_mem[i] = '0;
         value_mem[i] = '0;
         length_mem[i] = '0;
      end
      shift_reg = oaht_pkg::SHIFT_RESET;
      error_count = 0;
   endfunction

   function logic [31:0] mix_key(logic [63:0] k);
      k = (~k) + (k << 18);
      k = k ^ (k >> 31);
      k = k * 64'd21;
      k = k ^ (k >> 11);
      k = k + (k << 6);
      k = k ^ (k >> 22);
      return k[31:0];
   endfunction

   // Works out the response of one accepted request and updates the table copy.
   function void note_request(logic [1:0] mode, logic [63:0] key, logic [63:0] val,
                              logic [31:0] len);
      int unsigned sh, size, mask, idx, h, found_idx, empty_idx, tomb_idx, w;
      bit found, hit_empty, have_tomb;
      logic succ;
      logic [63:0] vout;
      logic [31:0] sout;
      logic [9:0] slot_out;
      sh = shift_reg;
      if (sh < 3) sh = 3;
      if (sh > 10) sh = 10;
      size = 1 << sh;
      mask = size - 1;
      found = 0; hit_empty = 0; have_tomb = 0;
      found_idx = 0; empty_idx = 0; tomb_idx = 0;
      succ = 0; vout = '0; sout = '0; slot_out = '0;
      if (mode == oaht_pkg::MODE_NOP) begin
         pending_success_full.push_back(2'b00);
         pending_value.push_back('0);
         pending_size.push_back('0);
         pending_slot.push_back('0);
         return;
      end
      h = mix_key(key);
      if (h < 2) h = 2;
      idx = h & mask;
      for (int unsigned i = 0; i < size; i++) begin
         if (status_mem[idx] == oaht_pkg::ST_EMPTY) begin
            hit_empty = 1; empty_idx = idx; break;
         end
         if (status_mem[idx] == oaht_pkg::ST_VALID && key_mem[idx] == key) begin
            found = 1; found_idx = idx; break;
         end
         if (status_mem[idx] == oaht_pkg::ST_TOMB && !have_tomb) begin
            have_tomb = 1; tomb_idx = idx;
         end
         idx = (idx + i + 1) & mask;
      end
      if (mode == oaht_pkg::MODE_LOOKUP) begin
         if (found) begin
            succ = 1; vout = value_mem[found_idx];
            sout = length_mem[found_idx]; slot_out = 10'(found_idx);
         end
      end else if (mode == oaht_pkg::MODE_INSERT) begin
         if (found) slot_out = 10'(found_idx);
         else if (have_tomb || hit_empty) begin
            w = have_tomb ? tomb_idx : empty_idx;
            status_mem[w] = oaht_pkg::ST_VALID;
            key_mem[w] = key; value_mem[w] = val; length_mem[w] = len;
            succ = 1; slot_out = 10'(w);
         end
      end else if (found) begin
         status_mem[found_idx] = oaht_pkg::ST_TOMB;
         length_mem[found_idx] = '0;
         succ = 1; slot_out = 10'(found_idx);
      end
      pending_success_full.push_back({succ, !found && !hit_empty});
      pending_value.push_back(vout);
      pending_size.push_back(sout);
      pending_slot.push_back(slot_out);
   endfunction

   function void check_response(logic succ, logic full, logic [63:0] vout,
                                logic [31:0] sout, logic [9:0] slot_out);
      logic [1:0] sf;
      if (pending_slot.size() == 0) begin
         $error("response with no request outstanding");
         error_count++;
         return;
      end
      sf = pending_success_full.pop_front();
      if (succ !== sf[1]) begin
         $error("success: expected %0d, actual %0d", sf[1], succ); error_count++;
      end
      if (full !== sf[0]) begin
         $error("table_full: expected %0d, actual %0d", sf[0], full); error_count++;
      end
      if (vout !== pending_value[0]) begin
         $error("value_out: expected %h, actual %h", pending_value[0], vout);
         error_count++;
      end
      if (sout !== pending_size[0]) begin
         $error("size_out: expected %h, actual %h", pending_size[0], sout);
         error_count++;
      end
      if (slot_out !== pending_slot[0]) begin
         $error("slot: expected %0d, actual %0d", pending_slot[0], slot_out);
         error_count++;
      end
      void'(pending_value.pop_front());
      void'(pending_size.pop_front());
      void'(pending_slot.pop_front());
   endfunction
endclass

module open_addressing_hash_table_test;
   import oaht_pkg::*;

   logic        clock = 0;
   logic        reset = 1;
   logic        start = 0;
   logic        busy;
   logic [1:0]  req_mode = MODE_LOOKUP;
   logic [63:0] req_key = '0;
   logic [63:0] req_value = '0;
   logic [31:0] req_range_len = '0;
   logic        rsp_valid;
   logic        rsp_success;
   logic        rsp_table_full;
   logic [63:0] rsp_value_out;
   logic [31:0] rsp_size_out;
   logic [SLOT_W-1:0] rsp_slot;
   logic        csr_we = 0;
   logic [3:0]  csr_wdata = '0;

   hash_table_scoreboard table_model = new();
   // Keys handed out so far; reusing them makes lookups and removes hit.
   logic [63:0] key_pool [$];
   longint unsigned cycle_count = 0;

   always #6 clock = ~clock;

   open_addressing_hash_table dut (.*);

   // Responses are sampled at the edge that ends their cycle.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (!reset && rsp_valid)
         table_model.check_response(rsp_success, rsp_table_full, rsp_value_out,
                                    rsp_size_out, rsp_slot);
      if (cycle_count > 3000000) begin
         $display("FAIL");
         $finish;
      end
   end

   // Issues one request transaction after a random gap and waits for acceptance.
   // Start stays high after acceptance until the next request or an idle point
   // lowers it; busy keeps the block from taking it again meanwhile.
   task automatic send_request(logic [1:0] mode, logic [63:0] key, logic [63:0] val,
                               logic [31:0] len);
      int gap;
      gap = $urandom_range(0, 11);
      if ($urandom_range(0, 3) == 0) gap = 0;
      if (gap != 0) begin
         start <= 0;
         repeat (gap) @(posedge clock);
      end
      start <= 1;
      req_mode <= mode; req_key <= key; req_value <= val; req_range_len <= len;
      @(posedge clock);
      while (busy) @(posedge clock);
      // Accepted at this edge: note it before the response can appear.
      table_model.note_request(mode, key, val, len);
   endtask

   // Register writes happen only with no transaction in flight.
   task automatic write_shift(logic [3:0] shift);
      start <= 0;
      while (table_model.pending_slot.size() != 0 || busy) @(posedge clock);
      repeat (4) @(posedge clock);
      csr_we <= 1; csr_wdata <= shift;
      @(posedge clock);
      csr_we <= 0;
      table_model.shift_reg = shift;
   endtask

   function automatic logic [63:0] random_word();
      return {$urandom, $urandom};
   endfunction

   function automatic logic [63:0] pick_key();
      if (key_pool.size() != 0 && $urandom_range(0, 2) != 0)
         return key_pool[$urandom_range(0, key_pool.size() - 1)];
      pick_key = random_word();
      key_pool.push_back(pick_key);
   endfunction

   task automatic random_phase(int count, int remove_weight);
      logic [1:0] mode;
      int r;
      for (int n = 0; n < count; n++) begin
         r = $urandom_range(0, 99);
         if (r < 3) mode = MODE_NOP;
         else if (r < 3 + remove_weight) mode = MODE_REMOVE;
         else if (r < 55) mode = MODE_INSERT;
         else mode = MODE_LOOKUP;
         send_request(mode, pick_key(), random_word(), $urandom);
      end
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 0;

      // Directed: field extremes and every mode at the full size.
      send_request(MODE_LOOKUP, 64'd0, '0, '0);
      send_request(MODE_INSERT, 64'd0, '1, '1);
      send_request(MODE_INSERT, '1, '0, '0);
      send_request(MODE_INSERT, 64'd0, 64'h5, 32'h5);  // duplicate key
      send_request(MODE_LOOKUP, 64'd0, '0, '0);
      send_request(MODE_LOOKUP, '1, '1, '1);
      send_request(MODE_NOP, '1, '1, '1);
      send_request(MODE_REMOVE, 64'd0, '0, '0);
      send_request(MODE_REMOVE, 64'd0, '0, '0);        // remove of absent key
      send_request(MODE_LOOKUP, 64'd0, '0, '0);
      send_request(MODE_INSERT, 64'd0, 64'h1234, 32'h77); // reuses the tombstone
      send_request(MODE_LOOKUP, 64'd0, '0, '0);

      // A shift below the range clamps to the minimum; fill the eight slots.
      write_shift(4'd0);
      for (int n = 0; n < 10; n++)
         send_request(MODE_INSERT, 64'h100 + 64'(n), random_word(), $urandom);
      send_request(MODE_LOOKUP, 64'hdead, '0, '0);     // full table, absent key
      send_request(MODE_REMOVE, 64'h103, '0, '0);
      send_request(MODE_INSERT, 64'hbeef, 64'h9, 32'h9); // full with a tombstone
      send_request(MODE_LOOKUP, 64'hbeef, '0, '0);
      random_phase(60, 15);

      write_shift(4'd15);
      key_pool.delete();
      random_phase(120, 10);

      write_shift(4'd4);
      key_pool.delete();
      random_phase(100, 20);

      write_shift(4'd3);
      key_pool.delete();
      random_phase(70, 25);

      write_shift(4'd10);
      key_pool.delete();
      random_phase(80, 10);

      start <= 0;
      while (table_model.pending_slot.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (table_model.error_count == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end
endmodule
